### rtl/dtfm_pkg.sv
package dtfm_pkg;

  // Automaton size limits
  localparam int MAX_STATES = 32;
  localparam int ROW_CAP    = (MAX_STATES < 32) ? MAX_STATES : 32;
  localparam int STATE_W    = 5;
  localparam int CNT_W      = $clog2(ROW_CAP + 1);
  // Distinguishability matrix: one row and one column per state plus the dead state
  localparam int MAT_N      = ROW_CAP + 1;

  typedef logic [STATE_W-1:0] state_idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [MAT_N-1:0]   mat_row_t;

  // One stored transition row
  typedef struct packed {
    logic       p1;
    logic       p0;
    state_idx_t s1;
    state_idx_t s0;
  } trow_t;

  localparam int TROW_W = $bits(trow_t);

  // Resolved successors; the dead state is index n
  typedef struct packed {
    cnt_t t0;
    cnt_t t1;
  } succ_t;

  // Pair lookup request to the matrix store
  typedef struct packed {
    logic valid;
    cnt_t a0;
    cnt_t b0;
    cnt_t a1;
    cnt_t b1;
  } lookup_t;

  // Matrix row write
  typedef struct packed {
    logic     en;
    cnt_t     addr;
    mat_row_t data;
  } mat_wr_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_REACH,
    S_SEED,
    S_ROW_RD,
    S_ROW_LD,
    S_PAIR,
    S_ROW_WR,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_SEND
  } seq_state_e;

  // Successors of a loaded row; absent or out-of-range moves go to the dead state
  function automatic succ_t next_pair(trow_t r, cnt_t n);
    succ_t s;
    s.t0 = (r.p0 && (cnt_t'(r.s0) < n)) ? cnt_t'(r.s0) : n;
    s.t1 = (r.p1 && (cnt_t'(r.s1) < n)) ? cnt_t'(r.s1) : n;
    return s;
  endfunction

  // Index of the lowest set bit (0 when none)
  function automatic state_idx_t lowest_set(logic [ROW_CAP-1:0] v);
    state_idx_t res;
    res = '0;
    for (int b = ROW_CAP - 1; b >= 0; b--) begin
      if (v[b]) res = state_idx_t'(b);
    end
    return res;
  endfunction

endpackage

### rtl/dtfm_row_if.sv
interface dtfm_row_if import dtfm_pkg::*;;
  logic       valid;
  logic       ready;
  state_idx_t next_on_zero;
  logic       zero_present;
  state_idx_t next_on_one;
  logic       one_present;
  logic       accepting;
  logic       last_row;

  modport source (
    output valid, next_on_zero, zero_present, next_on_one, one_present, accepting, last_row,
    input  ready
  );
  modport sink (
    input  valid, next_on_zero, zero_present, next_on_one, one_present, accepting, last_row,
    output ready
  );
endinterface

### rtl/dtfm_res_if.sv
interface dtfm_res_if import dtfm_pkg::*;;
  logic       valid;
  logic       ready;
  state_idx_t state_number;
  logic       is_reachable;
  logic       is_kept;
  state_idx_t representative;
  logic       final_result;

  modport source (
    output valid, state_number, is_reachable, is_kept, representative, final_result,
    input  ready
  );
  modport sink (
    input  valid, state_number, is_reachable, is_kept, representative, final_result,
    output ready
  );
endinterface

### rtl/dfa_table_filling_minimizer.sv
// Table-filling minimizer for a two-symbol automaton.
// row_i (valid/ready): one item per state row, in state order. ready is high
//   only while loading; a row is taken each cycle. Rows past 32 are dropped,
//   but a last_row flag on them still starts the run.
// res_o (valid/ready): after the run, one item per loaded state in index
//   order, final_result set on the last one.
// After the last row: reachability passes repeat until no state is added,
//   a seed sweep follows, then marking passes repeat until no pair changes,
//   and then the results are sent. The marking pass runs on the single
//   pair-compare unit, which checks one state pair per cycle against the
//   matrix store.
// One automaton is worked at a time; the next row is taken once the last
//   result has been delivered.
// A stalled receiver holds the current result in the output register and
//   the sequencer waits on it.
// Reset returns to loading with no rows held; the stores need no clearing.
module dfa_table_filling_minimizer import dtfm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dtfm_row_if.sink   row_i,
  dtfm_res_if.source res_o
);

  seq_state_e state_q, state_d;

  cnt_t row_count_q, row_count_d;
  cnt_t n_q, n_d;
  cnt_t i_q, i_d;
  cnt_t j_q, j_d;
  cnt_t i1_q, i1_d;
  cnt_t i2_q, i2_d;
  logic v1_q, v1_d;
  logic v2_q, v2_d;
  logic chg_q, chg_d;
  logic [ROW_CAP-1:0] reach_q, reach_d;
  logic [ROW_CAP-1:0] fin_q, fin_d;
  mat_row_t rowbuf_q, rowbuf_d;
  succ_t    sj_q, sj_d;

  logic       out_valid_q, out_valid_d;
  state_idx_t out_state_q, out_state_d;
  logic       out_reach_q, out_reach_d;
  logic       out_kept_q, out_kept_d;
  state_idx_t out_rep_q, out_rep_d;
  logic       out_last_q, out_last_d;

  logic row_acc, res_acc;
  cnt_t cnt_new;

  logic       tbl_we;
  trow_t      tbl_wdata;
  logic       tbl_re;
  state_idx_t tbl_raddr;
  trow_t      tbl_rd;
  logic [TROW_W-1:0] tbl_rdata;
  succ_t      succ_i;

  lookup_t  lookup;
  logic     row_rd_en;
  mat_wr_t  mat_wr;
  mat_row_t mat_row;
  mat_row_t seed_row;
  logic     mark0, mark1;
  logic     fin_j;

  state_idx_t         k_idx;
  logic [ROW_CAP-1:0] below_k, cand;
  state_idx_t         rep;

  assign row_acc = row_i.valid & row_i.ready;
  assign res_acc = res_o.valid & res_o.ready;
  assign cnt_new = (row_count_q < cnt_t'(ROW_CAP)) ? row_count_q + cnt_t'(1) : row_count_q;

  // Transition table store
  assign tbl_we    = row_acc & (row_count_q < cnt_t'(ROW_CAP));
  assign tbl_wdata = '{p1: row_i.one_present, p0: row_i.zero_present,
                       s1: row_i.next_on_one, s0: row_i.next_on_zero};
  assign tbl_rd    = trow_t'(tbl_rdata);
  assign succ_i    = next_pair(tbl_rd, n_q);

  dtfm_ram #(.Width(TROW_W), .Depth(ROW_CAP)) u_tbl (
    .clk_i,
    .we_i    (tbl_we),
    .waddr_i (row_count_q[STATE_W-1:0]),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  dtfm_dist_mem u_dist (
    .clk_i,
    .lookup_i      (lookup),
    .row_rd_en_i   (row_rd_en),
    .row_rd_addr_i (j_q),
    .wr_i          (mat_wr),
    .row_o         (mat_row),
    .mark0_o       (mark0),
    .mark1_o       (mark1)
  );

  // Seed row j: final/non-final pairs, dead state counted as non-final
  always_comb begin
    fin_j = (j_q < n_q) ? fin_q[j_q[STATE_W-1:0]] : 1'b0;
    seed_row = '0;
    for (int c = 0; c < ROW_CAP; c++) begin
      if (cnt_t'(c) < n_q) begin
        seed_row[c] = fin_q[c] ^ fin_j;
      end else if (cnt_t'(c) == n_q) begin
        seed_row[c] = fin_j;
      end
    end
    // Dead-state column of a full automaton
    if (n_q == cnt_t'(ROW_CAP)) seed_row[ROW_CAP] = fin_j;
  end

  // Representative search for result k
  always_comb begin
    k_idx   = j_q[STATE_W-1:0];
    below_k = (ROW_CAP'(1) << k_idx) - ROW_CAP'(1);
    cand    = reach_q & ~mat_row[ROW_CAP-1:0] & below_k;
    rep     = (reach_q[k_idx] && (|cand)) ? lowest_set(cand) : k_idx;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:     if (row_acc && row_i.last_row) state_d = S_REACH;
      S_REACH:    if (i_q == n_q && !v1_q && !chg_q) state_d = S_SEED;
      S_SEED:     if (j_q == n_q) state_d = S_ROW_RD;
      S_ROW_RD:   state_d = S_ROW_LD;
      S_ROW_LD:   state_d = S_PAIR;
      S_PAIR:     if (i_q == j_q && !v1_q && !v2_q) state_d = S_ROW_WR;
      S_ROW_WR:   state_d = (j_q == n_q && !chg_q) ? S_OUT_RD : S_ROW_RD;
      S_OUT_RD:   state_d = S_OUT_LD;
      S_OUT_LD:   state_d = S_OUT_SEND;
      S_OUT_SEND: begin
        if (res_acc) state_d = (j_q == n_q - cnt_t'(1)) ? S_LOAD : S_OUT_RD;
      end
      default:    state_d = S_LOAD;
    endcase
  end

  // Store controls per state
  always_comb begin
    row_i.ready = 1'b0;
    tbl_re      = 1'b0;
    tbl_raddr   = i_q[STATE_W-1:0];
    lookup      = '0;
    row_rd_en   = 1'b0;
    mat_wr      = '0;
    case (state_q)
      S_LOAD:  row_i.ready = 1'b1;
      S_REACH: tbl_re = (i_q < n_q);
      S_SEED:  mat_wr = '{en: 1'b1, addr: j_q, data: seed_row};
      S_ROW_RD: begin
        tbl_re    = (j_q < n_q);
        tbl_raddr = j_q[STATE_W-1:0];
        row_rd_en = 1'b1;
      end
      S_PAIR: begin
        tbl_re = (i_q < j_q);
        lookup = '{valid: v1_q, a0: succ_i.t0, b0: sj_q.t0, a1: succ_i.t1, b1: sj_q.t1};
      end
      S_ROW_WR: mat_wr = '{en: 1'b1, addr: j_q, data: rowbuf_q};
      S_OUT_RD: row_rd_en = 1'b1;
      default:  ;
    endcase
  end

  // Datapath updates
  always_comb begin
    row_count_d = row_count_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    i1_d        = i1_q;
    i2_d        = i2_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    chg_d       = chg_q;
    reach_d     = reach_q;
    fin_d       = fin_q;
    rowbuf_d    = rowbuf_q;
    sj_d        = sj_q;
    out_valid_d = out_valid_q;
    out_state_d = out_state_q;
    out_reach_d = out_reach_q;
    out_kept_d  = out_kept_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;
    case (state_q)
      S_LOAD: begin
        if (row_acc) begin
          if (tbl_we) fin_d[row_count_q[STATE_W-1:0]] = row_i.accepting;
          row_count_d = cnt_new;
          if (row_i.last_row) begin
            n_d     = cnt_new;
            i_d     = '0;
            v1_d    = 1'b0;
            chg_d   = 1'b0;
            reach_d = ROW_CAP'(1);
          end
        end
      end
      S_REACH: begin
        // Issue one row read per cycle
        v1_d = 1'b0;
        if (i_q < n_q) begin
          i_d  = i_q + cnt_t'(1);
          v1_d = 1'b1;
          i1_d = i_q;
        end
        // Spread reachability through the returned row
        if (v1_q && reach_q[i1_q[STATE_W-1:0]]) begin
          if (succ_i.t0 < n_q) begin
            if (!reach_q[succ_i.t0[STATE_W-1:0]]) chg_d = 1'b1;
            reach_d[succ_i.t0[STATE_W-1:0]] = 1'b1;
          end
          if (succ_i.t1 < n_q) begin
            if (!reach_q[succ_i.t1[STATE_W-1:0]]) chg_d = 1'b1;
            reach_d[succ_i.t1[STATE_W-1:0]] = 1'b1;
          end
        end
        // Pass finished: repeat while something grew
        if (i_q == n_q && !v1_q) begin
          if (chg_q) begin
            i_d   = '0;
            chg_d = 1'b0;
          end else begin
            j_d = '0;
          end
        end
      end
      S_SEED: begin
        if (j_q == n_q) begin
          j_d   = cnt_t'(1);
          chg_d = 1'b0;
        end else begin
          j_d = j_q + cnt_t'(1);
        end
      end
      S_ROW_LD: begin
        rowbuf_d = mat_row;
        sj_d     = (j_q < n_q) ? next_pair(tbl_rd, n_q) : '{t0: n_q, t1: n_q};
        i_d      = '0;
        v1_d     = 1'b0;
        v2_d     = 1'b0;
      end
      S_PAIR: begin
        // Stage 0: fetch row i
        v1_d = 1'b0;
        if (i_q < j_q) begin
          i_d  = i_q + cnt_t'(1);
          v1_d = 1'b1;
          i1_d = i_q;
        end
        // Stage 1: successor pair lookup issued through the store controls
        v2_d = v1_q;
        i2_d = i1_q;
        // Stage 2: mark pair (j, i)
        if (v2_q && (mark0 || mark1) && !rowbuf_q[i2_q]) begin
          rowbuf_d[i2_q] = 1'b1;
          chg_d          = 1'b1;
        end
      end
      S_ROW_WR: begin
        if (j_q == n_q) begin
          if (chg_q) begin
            j_d   = cnt_t'(1);
            chg_d = 1'b0;
          end else begin
            j_d = '0;
          end
        end else begin
          j_d = j_q + cnt_t'(1);
        end
      end
      S_OUT_LD: begin
        out_valid_d = 1'b1;
        out_state_d = k_idx;
        out_reach_d = reach_q[k_idx];
        out_kept_d  = reach_q[k_idx] && (rep == k_idx);
        out_rep_d   = rep;
        out_last_d  = (j_q == n_q - cnt_t'(1));
      end
      S_OUT_SEND: begin
        if (res_acc) begin
          out_valid_d = 1'b0;
          if (j_q == n_q - cnt_t'(1)) begin
            row_count_d = '0;
          end else begin
            j_d = j_q + cnt_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      row_count_q <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      chg_q       <= 1'b0;
      reach_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_count_q <= row_count_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      chg_q       <= chg_d;
      reach_q     <= reach_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i1_q        <= i1_d;
    i2_q        <= i2_d;
    fin_q       <= fin_d;
    rowbuf_q    <= rowbuf_d;
    sj_q        <= sj_d;
    out_state_q <= out_state_d;
    out_reach_q <= out_reach_d;
    out_kept_q  <= out_kept_d;
    out_rep_q   <= out_rep_d;
    out_last_q  <= out_last_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.state_number   = out_state_q;
  assign res_o.is_reachable   = out_reach_q;
  assign res_o.is_kept        = out_kept_q;
  assign res_o.representative = out_rep_q;
  assign res_o.final_result   = out_last_q;

  // Loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(row_i.ready && res_o.valid))
    else $error("row ready while a result is pending");

  // State 0 is reachable throughout a run
  a_start_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> reach_q[0])
    else $error("start state missing from reachable set");

  // Representative never lies above its state
  a_rep_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.representative <= res_o.state_number))
    else $error("representative above state index");

  // A kept state is reachable and its own representative
  a_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.is_kept) |->
      (res_o.is_reachable && res_o.representative == res_o.state_number))
    else $error("kept state inconsistent");

  // A result is up while waiting in the send state
  a_send_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_OUT_SEND) |-> res_o.valid)
    else $error("send state without a result");

endmodule

### rtl/dtfm_ram.sv
module dtfm_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dtfm_dist_mem.sv
module dtfm_dist_mem import dtfm_pkg::*; (
  input  logic     clk_i,
  input  lookup_t  lookup_i,
  input  logic     row_rd_en_i,
  input  cnt_t     row_rd_addr_i,
  input  mat_wr_t  wr_i,
  output mat_row_t row_o,
  output logic     mark0_o,
  output logic     mark1_o
);

  cnt_t     hi0, lo0, hi1, lo1;
  cnt_t     lo0_q, lo1_q;
  logic     eq0_q, eq1_q;
  cnt_t     rd0_addr;
  logic     rd0_en;
  mat_row_t rdata0, rdata1;

  // Fold each pair into the lower triangle: row = larger index, column = smaller
  always_comb begin
    hi0 = (lookup_i.a0 > lookup_i.b0) ? lookup_i.a0 : lookup_i.b0;
    lo0 = (lookup_i.a0 > lookup_i.b0) ? lookup_i.b0 : lookup_i.a0;
    hi1 = (lookup_i.a1 > lookup_i.b1) ? lookup_i.a1 : lookup_i.b1;
    lo1 = (lookup_i.a1 > lookup_i.b1) ? lookup_i.b1 : lookup_i.a1;
  end

  // Port 0 serves lookups and whole-row reads
  assign rd0_en   = lookup_i.valid | row_rd_en_i;
  assign rd0_addr = lookup_i.valid ? hi0 : row_rd_addr_i;

  // Column selects travel alongside the registered read
  always_ff @(posedge clk_i) begin
    if (lookup_i.valid) begin
      lo0_q <= lo0;
      lo1_q <= lo1;
      eq0_q <= (lookup_i.a0 == lookup_i.b0);
      eq1_q <= (lookup_i.a1 == lookup_i.b1);
    end
  end

  // Two copies written alike give two lookups per cycle
  dtfm_ram #(.Width(MAT_N), .Depth(MAT_N)) u_mat0 (
    .clk_i,
    .we_i    (wr_i.en),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .re_i    (rd0_en),
    .raddr_i (rd0_addr),
    .rdata_o (rdata0)
  );

  dtfm_ram #(.Width(MAT_N), .Depth(MAT_N)) u_mat1 (
    .clk_i,
    .we_i    (wr_i.en),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .re_i    (lookup_i.valid),
    .raddr_i (hi1),
    .rdata_o (rdata1)
  );

  // A state is never distinguishable from itself
  assign row_o   = rdata0;
  assign mark0_o = ~eq0_q & rdata0[lo0_q];
  assign mark1_o = ~eq1_q & rdata1[lo1_q];

endmodule
